// ===== hdl/fnu_pkg.sv =====
// ----------------------------------------------------------------------------
// fnu_pkg: face normal unit shared definitions
// Widths of the arithmetic chain and the side-band records passed between the
// root and divider pipelines.
// ----------------------------------------------------------------------------
package fnu_pkg;

	localparam int COORD_WIDTH      = 16;
	localparam int NORMAL_FRAC_BITS = 14;
	localparam int NORM_BITS        = 31;

	localparam int EDGE_W   = COORD_WIDTH + 1;
	localparam int PROD_W   = 2 * EDGE_W;
	localparam int CROSS_W  = PROD_W + 1;
	localparam int MAG_W    = CROSS_W;
	localparam int LEN_W    = $clog2(MAG_W + 1);
	localparam int M_W      = NORM_BITS;
	localparam int SQ_W     = 2 * M_W;
	localparam int SUM_W    = SQ_W + 2;
	localparam int ROOT_W   = SUM_W / 2;
	localparam int REM_W    = ROOT_W + 2;
	localparam int QUO_W    = NORMAL_FRAC_BITS + 1;
	localparam int DIV_W    = ROOT_W + QUO_W;
	localparam int OUT_W    = NORMAL_FRAC_BITS + 2;

	localparam int IN_DATA_W  = ((9 * COORD_WIDTH + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((3 * OUT_W + 7) / 8) * 8;

	typedef struct packed {
		logic [2:0] neg;
		logic       deg;
		logic       last;
	} fnu_flags_t;

	typedef struct packed {
		logic [2:0][M_W-1:0] m;
		fnu_flags_t          flg;
	} fnu_side_t;

	typedef struct packed {
		logic [2:0][OUT_W-1:0] nrm;
		logic                  deg;
		logic                  last;
	} fnu_out_t;

endpackage

// ===== hdl/fnu_sqrt.sv =====
// ----------------------------------------------------------------------------
// fnu_sqrt: pipelined integer square root
// One root bit per stage, floor result; side-band record rides along.
// ----------------------------------------------------------------------------
module fnu_sqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [fnu_pkg::SUM_W-1:0]   rad,
	input  fnu_pkg::fnu_side_t          in_side,
	output logic                        out_valid,
	output logic [fnu_pkg::ROOT_W-1:0]  root,
	output fnu_pkg::fnu_side_t          out_side
);
	import fnu_pkg::*;

	logic              vld_c  [ROOT_W+1];
	logic [SUM_W-1:0]  rad_c  [ROOT_W+1];
	logic [REM_W-1:0]  rem_c  [ROOT_W+1];
	logic [ROOT_W-1:0] root_c [ROOT_W+1];
	fnu_side_t         side_c [ROOT_W+1];

	assign vld_c[0]  = in_valid;
	assign rad_c[0]  = rad;
	assign rem_c[0]  = '0;
	assign root_c[0] = '0;
	assign side_c[0] = in_side;

	for (genvar k = 0; k < ROOT_W; k++) begin : g_step
		logic [REM_W-1:0]  rem_raw;
		logic [REM_W-1:0]  trial;
		logic              ge;
		logic              vld_s;
		logic [SUM_W-1:0]  rad_s;
		logic [REM_W-1:0]  rem_s;
		logic [ROOT_W-1:0] root_s;
		fnu_side_t         side_s;

		// bring down the next two radicand bits, try root*4+1
		assign rem_raw = {rem_c[k][REM_W-3:0], rad_c[k][SUM_W-1 -: 2]};
		assign trial   = {root_c[k], 2'b01};
		assign ge      = (rem_raw >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s <= 1'b0;
			end else if (en) begin
				vld_s <= vld_c[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s  <= {rad_c[k][SUM_W-3:0], 2'b00};
				rem_s  <= ge ? (rem_raw - trial) : rem_raw;
				root_s <= {root_c[k][ROOT_W-2:0], ge};
				side_s <= side_c[k];
			end
		end

		assign vld_c[k+1]  = vld_s;
		assign rad_c[k+1]  = rad_s;
		assign rem_c[k+1]  = rem_s;
		assign root_c[k+1] = root_s;
		assign side_c[k+1] = side_s;
	end

	assign out_valid = vld_c[ROOT_W];
	assign root      = root_c[ROOT_W];
	assign out_side  = side_c[ROOT_W];

endmodule

// ===== hdl/fnu_div.sv =====
// ----------------------------------------------------------------------------
// fnu_div: three-lane pipelined rounding divider
// q = (m * 2^F + floor(n/2)) / n, one quotient bit per stage, restoring form.
// ----------------------------------------------------------------------------
module fnu_div (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  logic                                  in_valid,
	input  logic [fnu_pkg::ROOT_W-1:0]            n,
	input  logic [2:0][fnu_pkg::M_W-1:0]          m,
	input  fnu_pkg::fnu_flags_t                   in_flags,
	output logic                                  out_valid,
	output logic [2:0][fnu_pkg::QUO_W-1:0]        q,
	output fnu_pkg::fnu_flags_t                   out_flags
);
	import fnu_pkg::*;

	logic                     vld_c [QUO_W+1];
	logic [ROOT_W-1:0]        dvs_c [QUO_W+1];
	logic [2:0][DIV_W-1:0]    r_c   [QUO_W+1];
	logic [2:0][QUO_W-1:0]    q_c   [QUO_W+1];
	fnu_flags_t               flg_c [QUO_W+1];

	// numerator stage: add half the divisor for round-half-up
	logic                     vld_s0;
	logic [ROOT_W-1:0]        dvs_s0;
	logic [2:0][DIV_W-1:0]    num_s0;
	fnu_flags_t               flg_s0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s0 <= 1'b0;
		end else if (en) begin
			vld_s0 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dvs_s0 <= n;
			flg_s0 <= in_flags;
			for (int i = 0; i < 3; i++) begin
				num_s0[i] <= (DIV_W'(m[i]) << NORMAL_FRAC_BITS) + DIV_W'(n >> 1);
			end
		end
	end

	assign vld_c[0] = vld_s0;
	assign dvs_c[0] = dvs_s0;
	assign r_c[0]   = num_s0;
	assign q_c[0]   = '0;
	assign flg_c[0] = flg_s0;

	for (genvar j = 0; j < QUO_W; j++) begin : g_step
		localparam int SH = QUO_W - 1 - j;
		logic [DIV_W-1:0]      d;
		logic [2:0]            ge;
		logic                  vld_s;
		logic [ROOT_W-1:0]     dvs_s;
		logic [2:0][DIV_W-1:0] r_s;
		logic [2:0][QUO_W-1:0] q_s;
		fnu_flags_t            flg_s;

		assign d = DIV_W'(dvs_c[j]) << SH;

		always_comb begin
			for (int i = 0; i < 3; i++) begin
				ge[i] = (r_c[j][i] >= d);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s <= 1'b0;
			end else if (en) begin
				vld_s <= vld_c[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dvs_s <= dvs_c[j];
				flg_s <= flg_c[j];
				for (int i = 0; i < 3; i++) begin
					r_s[i] <= ge[i] ? (r_c[j][i] - d) : r_c[j][i];
					q_s[i] <= {q_c[j][i][QUO_W-2:0], ge[i]};
				end
			end
		end

		assign vld_c[j+1] = vld_s;
		assign dvs_c[j+1] = dvs_s;
		assign r_c[j+1]   = r_s;
		assign q_c[j+1]   = q_s;
		assign flg_c[j+1] = flg_s;
	end

	assign out_valid = vld_c[QUO_W];
	assign q         = q_c[QUO_W];
	assign out_flags = flg_c[QUO_W];

endmodule

// ===== hdl/face_normal_unit.sv =====
// ----------------------------------------------------------------------------
// face_normal_unit: unit normal of a triangle face
// Edge vectors, exact cross product, normalize to unit length in Q2.14.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_*: one request per face. s_tdata carries the three
//   vertices as nine signed 16-bit coordinates (4 fraction bits), s_tlast
//   marks the last face of the array.
//   Master channel m_*: one result per face, in order. m_tdata carries the
//   normal x, y, z in signed Q2.14, m_tuser is set for a degenerate face
//   (zero cross product; normal reads zero), m_tlast copies s_tlast.
//   Throughput: one face per cycle while the skid register is empty.
//   Pipeline: the 8-stage front end, the 32-stage root pipeline and the
//   16-stage divider, followed by the output register.
//   Stall: an output register backed by a skid register; when the skid
//   register fills, the whole pipeline holds and s_tready drops, with
//   s_tready driven from a register only.
//   Reset: arst_n clears all valid bits; no result is pending afterwards.
// ----------------------------------------------------------------------------
module face_normal_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z
	input  logic [fnu_pkg::IN_DATA_W-1:0]     s_tdata,
	input  logic                              s_tlast,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// normal_x, normal_y, normal_z
	output logic [fnu_pkg::OUT_DATA_W-1:0]    m_tdata,
	// degenerate
	output logic                              m_tuser,
	output logic                              m_tlast
);
	import fnu_pkg::*;

	function automatic logic signed [PROD_W-1:0] smul(
		input logic signed [EDGE_W-1:0] x,
		input logic signed [EDGE_W-1:0] y
	);
		logic signed [PROD_W-1:0] xe;
		logic signed [PROD_W-1:0] ye;
		xe   = PROD_W'(x);
		ye   = PROD_W'(y);
		smul = xe * ye;
	endfunction

	logic adv;

	// ---------------------------------------------------------------- s1
	logic [COORD_WIDTH-1:0]   vin [9];
	logic                     vld_s1;
	logic                     last_s1;
	logic signed [EDGE_W-1:0] a_s1 [3];
	logic signed [EDGE_W-1:0] b_s1 [3];

	always_comb begin
		for (int i = 0; i < 9; i++) begin
			vin[i] = s_tdata[i*COORD_WIDTH +: COORD_WIDTH];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			last_s1 <= s_tlast;
			for (int i = 0; i < 3; i++) begin
				a_s1[i] <= {vin[i][COORD_WIDTH-1], vin[i]}
					- {vin[i+3][COORD_WIDTH-1], vin[i+3]};
				b_s1[i] <= {vin[i][COORD_WIDTH-1], vin[i]}
					- {vin[i+6][COORD_WIDTH-1], vin[i+6]};
			end
		end
	end

	// ---------------------------------------------------------------- s2
	logic                     vld_s2;
	logic                     last_s2;
	logic signed [PROD_W-1:0] p_s2 [6];

	always_ff @(posedge clk) begin
		if (adv) begin
			last_s2 <= last_s1;
			p_s2[0] <= smul(a_s1[1], b_s1[2]);
			p_s2[1] <= smul(a_s1[2], b_s1[1]);
			p_s2[2] <= smul(a_s1[2], b_s1[0]);
			p_s2[3] <= smul(a_s1[0], b_s1[2]);
			p_s2[4] <= smul(a_s1[0], b_s1[1]);
			p_s2[5] <= smul(a_s1[1], b_s1[0]);
		end
	end

	// ---------------------------------------------------------------- s3
	logic                      vld_s3;
	logic                      last_s3;
	logic signed [CROSS_W-1:0] c_s3 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			last_s3 <= last_s2;
			for (int i = 0; i < 3; i++) begin
				c_s3[i] <= CROSS_W'(p_s2[2*i]) - CROSS_W'(p_s2[2*i+1]);
			end
		end
	end

	// ---------------------------------------------------------------- s4
	logic             vld_s4;
	logic             last_s4;
	logic [2:0]       neg_s4;
	logic [MAG_W-1:0] mag_s4 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			last_s4 <= last_s3;
			for (int i = 0; i < 3; i++) begin
				neg_s4[i] <= c_s3[i][CROSS_W-1];
				mag_s4[i] <= c_s3[i][CROSS_W-1] ? (MAG_W'(0) - MAG_W'(c_s3[i]))
					: MAG_W'(c_s3[i]);
			end
		end
	end

	// ---------------------------------------------------------------- s5
	logic             vld_s5;
	logic             last_s5;
	logic [2:0]       neg_s5;
	logic [MAG_W-1:0] mag_s5 [3];
	logic [LEN_W-1:0] len_s5;
	logic [MAG_W-1:0] mag_or;
	logic [LEN_W-1:0] len_c;

	// bit length of the largest magnitude
	always_comb begin
		mag_or = mag_s4[0] | mag_s4[1] | mag_s4[2];
		len_c  = '0;
		for (int i = 0; i < MAG_W; i++) begin
			if (mag_or[i]) begin
				len_c = LEN_W'(i + 1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			last_s5 <= last_s4;
			neg_s5  <= neg_s4;
			mag_s5  <= mag_s4;
			len_s5  <= len_c;
		end
	end

	// ---------------------------------------------------------------- s6
	logic                 vld_s6;
	logic                 last_s6;
	logic                 deg_s6;
	logic [2:0]           neg_s6;
	logic [M_W-1:0]       m_s6 [3];
	logic [MAG_W+M_W-1:0] shw [3];

	// (mag << NORM_BITS) >> len puts the top bit at NORM_BITS-1
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			shw[i] = {mag_s5[i], {M_W{1'b0}}} >> len_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			last_s6 <= last_s5;
			neg_s6  <= neg_s5;
			deg_s6  <= (len_s5 == '0);
			for (int i = 0; i < 3; i++) begin
				m_s6[i] <= shw[i][M_W-1:0];
			end
		end
	end

	// ---------------------------------------------------------------- s7
	logic            vld_s7;
	logic            last_s7;
	logic            deg_s7;
	logic [2:0]      neg_s7;
	logic [M_W-1:0]  m_s7  [3];
	logic [SQ_W-1:0] sq_s7 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			last_s7 <= last_s6;
			neg_s7  <= neg_s6;
			deg_s7  <= deg_s6;
			m_s7    <= m_s6;
			for (int i = 0; i < 3; i++) begin
				sq_s7[i] <= SQ_W'(m_s6[i]) * SQ_W'(m_s6[i]);
			end
		end
	end

	// ---------------------------------------------------------------- s8
	logic             vld_s8;
	logic [SUM_W-1:0] sum_s8;
	fnu_side_t        side_s8;

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s8           <= SUM_W'(sq_s7[0]) + SUM_W'(sq_s7[1]) + SUM_W'(sq_s7[2]);
			side_s8.m[0]     <= m_s7[0];
			side_s8.m[1]     <= m_s7[1];
			side_s8.m[2]     <= m_s7[2];
			side_s8.flg.neg  <= neg_s7;
			side_s8.flg.deg  <= deg_s7;
			side_s8.flg.last <= last_s7;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= s_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
		end
	end

	// ------------------------------------------------- root and divide
	logic                  rt_valid;
	logic [ROOT_W-1:0]     rt_root;
	fnu_side_t             rt_side;
	logic                  dv_valid;
	logic [2:0][QUO_W-1:0] dv_q;
	fnu_flags_t            dv_flags;

	fnu_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (vld_s8),
		.rad       (sum_s8),
		.in_side   (side_s8),
		.out_valid (rt_valid),
		.root      (rt_root),
		.out_side  (rt_side)
	);

	fnu_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (rt_valid),
		.n         (rt_root),
		.m         (rt_side.m),
		.in_flags  (rt_side.flg),
		.out_valid (dv_valid),
		.q         (dv_q),
		.out_flags (dv_flags)
	);

	// ------------------------------------------------- sign and output
	fnu_out_t res_c;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (dv_flags.deg) begin
				res_c.nrm[i] = '0;
			end else if (dv_flags.neg[i]) begin
				res_c.nrm[i] = OUT_W'(0) - OUT_W'(dv_q[i]);
			end else begin
				res_c.nrm[i] = OUT_W'(dv_q[i]);
			end
		end
		res_c.deg  = dv_flags.deg;
		res_c.last = dv_flags.last;
	end

	fnu_out_t out_q;
	fnu_out_t skid_q;
	logic     out_vld_q;
	logic     skid_vld_q;
	logic     wr;

	assign adv = !skid_vld_q;
	assign wr  = dv_valid && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!out_vld_q || m_tready) begin
			out_vld_q  <= skid_vld_q || wr;
			skid_vld_q <= 1'b0;
		end else if (wr) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || m_tready) begin
			out_q <= skid_vld_q ? skid_q : res_c;
		end else if (wr) begin
			skid_q <= res_c;
		end
	end

	assign s_tready = adv;
	assign m_tvalid = out_vld_q;
	assign m_tdata  = OUT_DATA_W'(out_q.nrm);
	assign m_tuser  = out_q.deg;
	assign m_tlast  = out_q.last;

	// ------------------------------------------------------- checks
	localparam logic signed [OUT_W-1:0] UNIT = OUT_W'(1) << NORMAL_FRAC_BITS;

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid entry held without a pending output");

	a_skid_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_vld_q) |-> $past(out_vld_q && !m_tready))
		else $error("skid register filled without an output stall");

	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && out_q.deg) |-> (out_q.nrm == '0))
		else $error("degenerate face with nonzero normal");

	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> ($signed(out_q.nrm[0]) <= UNIT && $signed(out_q.nrm[0]) >= -UNIT
			&& $signed(out_q.nrm[1]) <= UNIT && $signed(out_q.nrm[1]) >= -UNIT
			&& $signed(out_q.nrm[2]) <= UNIT && $signed(out_q.nrm[2]) >= -UNIT))
		else $error("normal component beyond unit range");

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: face normal unit testbench
// Drives faces into the stream input with bursty timing while the output
// side stalls in changing patterns. Each accepted face is run through a
// local fixed-point normal calculation and every returned normal is checked
// in order against it.
// ----------------------------------------------------------------------------
module tb_top;
	import fnu_pkg::*;

	typedef struct packed {
		logic [8:0][COORD_WIDTH-1:0] crd;   // v0 xyz, v1 xyz, v2 xyz, lowest first
		logic                        last;
	} face_t;

	typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_PERIODIC, RX_CHOKE} rx_mode_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;    // v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z
	logic                  s_tlast;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;    // normal_x, normal_y, normal_z
	logic                  m_tuser;    // degenerate
	logic                  m_tlast;

	fnu_out_t pending_normals[$];
	int       mismatch_count = 0;
	int       burst_left     = 0;
	bit       sender_gaps    = 1'b1;
	rx_mode_t rx_mode        = RX_OPEN;
	int       rx_left        = 0;
	int       rx_tick        = 0;
	fnu_out_t want, seen;

	face_normal_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#10_000_000;
		$display("tb_top: done, errors");
		$finish;
	end

	// ---------------------------------------------------------------- predictor

	function automatic int bit_len(input logic [63:0] v);
		int n;
		n = 0;
		for (int k = 0; k < 64; k++)
			if (v[k]) n = k + 1;
		return n;
	endfunction

	function automatic logic [63:0] int_sqrt(input logic [63:0] v);
		logic [63:0] res, probe;
		res   = '0;
		probe = 64'h1 << 62;
		while (probe > v) probe = probe >> 2;
		while (probe != 0) begin
			if (v >= res + probe) begin
				v   = v - (res + probe);
				res = (res >> 1) + probe;
			end else
				res = res >> 1;
			probe = probe >> 2;
		end
		return res;
	endfunction

	function automatic fnu_out_t predict_normal(input face_t f);
		longint      p[9];
		longint      ax, ay, az, bx, by, bz;
		longint      cr[3];
		logic [63:0] mg[3], m[3], sq, root, q;
		logic [2:0]  neg;
		int          len;
		fnu_out_t    r;
		for (int i = 0; i < 9; i++) p[i] = longint'($signed(f.crd[i]));
		ax = p[0] - p[3]; ay = p[1] - p[4]; az = p[2] - p[5];
		bx = p[0] - p[6]; by = p[1] - p[7]; bz = p[2] - p[8];
		cr[0] = ay * bz - az * by;
		cr[1] = az * bx - ax * bz;
		cr[2] = ax * by - ay * bx;
		len = 0;
		for (int i = 0; i < 3; i++) begin
			neg[i] = cr[i] < 0;
			mg[i]  = neg[i] ? 64'(-cr[i]) : 64'(cr[i]);
			if (bit_len(mg[i]) > len) len = bit_len(mg[i]);
		end
		r.last = f.last;
		if (len == 0) begin
			r.nrm = '0;
			r.deg = 1'b1;
			return r;
		end
		// common shift so the largest magnitude sits at NORM_BITS bits
		for (int i = 0; i < 3; i++)
			m[i] = (len > NORM_BITS) ? mg[i] >> (len - NORM_BITS) : mg[i] << (NORM_BITS - len);
		sq   = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
		root = int_sqrt(sq);
		for (int i = 0; i < 3; i++) begin
			q = ((m[i] << NORMAL_FRAC_BITS) + (root >> 1)) / root;
			r.nrm[i] = neg[i] ? OUT_W'(-q) : OUT_W'(q);
		end
		r.deg = 1'b0;
		return r;
	endfunction

	// ---------------------------------------------------------------- stimulus

	function automatic face_t make_face(input int x0, y0, z0, x1, y1, z1, x2, y2, z2,
			input logic last);
		face_t f;
		f.crd[0] = COORD_WIDTH'(x0); f.crd[1] = COORD_WIDTH'(y0); f.crd[2] = COORD_WIDTH'(z0);
		f.crd[3] = COORD_WIDTH'(x1); f.crd[4] = COORD_WIDTH'(y1); f.crd[5] = COORD_WIDTH'(z1);
		f.crd[6] = COORD_WIDTH'(x2); f.crd[7] = COORD_WIDTH'(y2); f.crd[8] = COORD_WIDTH'(z2);
		f.last   = last;
		return f;
	endfunction

	// base plus a random signed offset below 2**k (wraps at the field width)
	function automatic logic [COORD_WIDTH-1:0] spread(input logic [COORD_WIDTH-1:0] base,
			input int k);
		logic [COORD_WIDTH-1:0] d;
		d = COORD_WIDTH'($urandom_range(0, (1 << k) - 1));
		return $urandom_range(0, 1) ? base + d : base - d;
	endfunction

	function automatic face_t random_face();
		face_t                  f;
		int                     k, j;
		logic [COORD_WIDTH-1:0] d;
		for (int i = 0; i < 9; i++) f.crd[i] = COORD_WIDTH'($urandom);
		f.last = ($urandom_range(0, 7) == 0);
		case ($urandom_range(0, 9))
			4, 5, 6: begin
				k = $urandom_range(0, 15);
				for (int i = 0; i < 3; i++) begin
					f.crd[3 + i] = spread(f.crd[i], k);
					f.crd[6 + i] = spread(f.crd[i], k);
				end
			end
			7: begin
				// flat in one axis: two normal components come out zero
				j = $urandom_range(0, 2);
				f.crd[3 + j] = f.crd[j];
				f.crd[6 + j] = f.crd[j];
			end
			8: begin
				k = $urandom_range(0, 12);
				case ($urandom_range(0, 3))
					0: for (int i = 0; i < 3; i++) f.crd[3 + i] = f.crd[i];
					1: for (int i = 0; i < 3; i++) f.crd[6 + i] = f.crd[i];
					2: for (int i = 0; i < 3; i++) f.crd[6 + i] = f.crd[3 + i];
					default:
						for (int i = 0; i < 3; i++) begin
							d = spread('0, k);
							f.crd[3 + i] = f.crd[i] + d;
							f.crd[6 + i] = f.crd[i] + d + d;
						end
				endcase
			end
			9: begin
				k = $urandom_range(1, 3);
				for (int i = 0; i < 3; i++) begin
					f.crd[3 + i] = spread(f.crd[i], k);
					f.crd[6 + i] = spread(f.crd[i], k);
				end
			end
			default: ;
		endcase
		return f;
	endfunction

	task automatic send_face(input face_t f);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			if (sender_gaps) begin
				gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 6);
				repeat (gap) begin
					@(negedge clk);
					s_tvalid = 1'b0;
				end
			end
		end
		burst_left--;
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tdata  = IN_DATA_W'(f.crd);
		s_tlast  = f.last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pending_normals = {pending_normals, predict_normal(f)};
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (pending_normals.size() != 0) @(posedge clk);
	endtask

	// ---------------------------------------------------------------- tests

	task automatic test_axis_normals();
		send_face(make_face(0, 0, 0, 16, 0, 0, 0, 16, 0, 1'b0));
		send_face(make_face(0, 0, 0, 0, 16, 0, 16, 0, 0, 1'b0));
		send_face(make_face(0, 0, 0, 0, 16, 0, 0, 0, 16, 1'b0));
		send_face(make_face(0, 0, 0, 0, 0, 16, 0, 16, 0, 1'b0));
		send_face(make_face(0, 0, 0, 0, 0, 16, 16, 0, 0, 1'b0));
		send_face(make_face(0, 0, 0, 16, 0, 0, 0, 0, 16, 1'b1));
		// diagonal normal, rounding of 1/sqrt(3)
		send_face(make_face(16, 0, 0, 0, 16, 0, 0, 0, 16, 1'b0));
		// smallest nonzero cross product
		send_face(make_face(100, 200, -300, 101, 200, -300, 100, 201, -300, 1'b0));
	endtask

	task automatic test_extreme_coords();
		send_face(make_face(32767, 32767, 32767, -32768, -32768, -32768,
			32767, -32768, 32767, 1'b0));
		send_face(make_face(-32768, -32768, -32768, 32767, 32767, 32767,
			-32768, 32767, 32767, 1'b1));
		send_face(make_face(32767, -32768, 0, -32768, 32767, 0, -32768, -32768, 0, 1'b0));
		send_face(make_face(32767, 32767, -32768, -32768, 32767, 32767,
			32767, -32768, 32767, 1'b0));
		send_face(make_face(-32768, 0, 32767, 32767, -32768, 0, 0, 32767, -32768, 1'b1));
		send_face(make_face(-1, -1, -1, 32767, -32768, -1, -32768, -1, 32767, 1'b0));
	endtask

	task automatic test_degenerate_faces();
		send_face(make_face(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
		send_face(make_face(1234, -555, 32767, 1234, -555, 32767, 1234, -555, 32767, 1'b1));
		send_face(make_face(-7, 8, 9, 300, -400, 500, 300, -400, 500, 1'b0));
		send_face(make_face(0, 0, 0, 10, 20, 30, 20, 40, 60, 1'b0));
		send_face(make_face(-32768, -32768, -32768, 0, 0, 0, 32767, 32767, 32767, 1'b1));
	endtask

	// sender holds off until the pipeline is empty, then restarts at full rate
	task automatic test_drain_pause();
		repeat (60) send_face(random_face());
		wait_drained();
		sender_gaps = 1'b0;
		burst_left  = 0;
		repeat (120) send_face(random_face());
		sender_gaps = 1'b1;
	endtask

	task automatic test_random_faces(input int count);
		repeat (count) send_face(random_face());
	endtask

	// ---------------------------------------------------------------- output side

	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_left = $urandom_range(16, 200);
		end
		rx_left--;
		rx_tick++;
		case (rx_mode)
			RX_OPEN:     m_tready = 1'b1;
			RX_COIN:     m_tready = ($urandom_range(0, 1) == 1);
			RX_PERIODIC: m_tready = ((rx_tick % 7) >= 3);
			default:     m_tready = ($urandom_range(0, 11) == 0);
		endcase
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			seen.nrm  = m_tdata[3*OUT_W-1:0];
			seen.deg  = m_tuser;
			seen.last = m_tlast;
			if (pending_normals.size() == 0) begin
				$display("%0t: result with no face pending: expected none, got %h", $time, seen);
				mismatch_count++;
			end else begin
				want = pending_normals.pop_front();
				for (int i = 0; i < 3; i++)
					if (seen.nrm[i] !== want.nrm[i]) begin
						$display("%0t: normal[%0d] expected %0d got %0d", $time, i,
							$signed(want.nrm[i]), $signed(seen.nrm[i]));
						mismatch_count++;
					end
				if (seen.deg !== want.deg) begin
					$display("%0t: degenerate expected %0b got %0b", $time, want.deg, seen.deg);
					mismatch_count++;
				end
				if (seen.last !== want.last) begin
					$display("%0t: last expected %0b got %0b", $time, want.last, seen.last);
					mismatch_count++;
				end
			end
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tlast  = 1'b0;
		m_tready = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_axis_normals();
		test_extreme_coords();
		test_degenerate_faces();
		test_drain_pause();
		test_random_faces(1400);

		wait_drained();
		repeat (80) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/fnu_pkg.sv
hdl/fnu_sqrt.sv
hdl/fnu_div.sv
hdl/face_normal_unit.sv
tb/tb_top.sv
